/* hdl/ptrc_pkg.sv */
// types and constants for the trusted producer replay check
// no dependencies; used by ptrc_table, ptrc_check and the top level
`default_nettype none

package ptrc_pkg;

  localparam logic REQ_INSTALL  = 1'b0;
  localparam logic REQ_VALIDATE = 1'b1;

  localparam logic [1:0] CRED_EXPIRED = 2'd1;
  localparam logic [1:0] CRED_REVOKED = 2'd2;

  typedef enum logic [3:0] {
    RSN_OK           = 4'd0,
    RSN_EXPIRED      = 4'd1,
    RSN_REVOKED      = 4'd2,
    RSN_SPOOFED      = 4'd3,
    RSN_UNKNOWN      = 4'd4,
    RSN_OLD_EPOCH    = 4'd5,
    RSN_FUTURE_EPOCH = 4'd6,
    RSN_REPLAY       = 4'd7,
    RSN_INVALID      = 4'd8,
    RSN_DUPLICATE    = 4'd9,
    RSN_FULL         = 4'd10
  } reason_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] claimed_id;
    logic [63:0] claimed_boot;
    logic [31:0] auth_id;
    logic [63:0] auth_boot;
    logic [1:0]  cred_status;
    logic [63:0] epoch;
    logic [63:0] sequence_req;
  } req_t;

  // what the table reports for the current key
  typedef struct packed {
    logic        hit;
    logic        full;
    logic [63:0] epoch;
    logic [63:0] last_seq;
  } lookup_t;

  // table write strobes
  typedef struct packed {
    logic install;
    logic update;
  } wr_t;

endpackage

`default_nettype wire

/* hdl/ptrc_if.sv */
// request and response channel interfaces of the replay check
// depends on nothing; used by the top level
`default_nettype none

interface ptrc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] claimed_id;
  logic [63:0] claimed_boot;
  logic [31:0] auth_id;
  logic [63:0] auth_boot;
  logic [1:0]  cred_status;
  logic [63:0] epoch;
  logic [63:0] sequence_req;

  modport source (
    output valid, req_type, claimed_id, claimed_boot, auth_id, auth_boot,
           cred_status, epoch, sequence_req,
    input  ready
  );
  modport sink (
    input  valid, req_type, claimed_id, claimed_boot, auth_id, auth_boot,
           cred_status, epoch, sequence_req,
    output ready
  );
endinterface

interface ptrc_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [3:0] reason;

  modport source (output valid, accepted, reason, input ready);
  modport sink (input valid, accepted, reason, output ready);
endinterface

`default_nettype wire

/* hdl/ptrc_table.sv */
// trusted producer table: parallel key match, lowest free slot, entry writes
// depends on ptrc_pkg
`default_nettype none

module ptrc_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [31:0]       key_id_i,
  input  wire logic [63:0]       key_boot_i,
  input  wire logic [63:0]       ins_epoch_i,
  input  wire logic [63:0]       seq_i,
  input  wire ptrc_pkg::wr_t     wr_i,
  output ptrc_pkg::lookup_t      lookup_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [31:0]              id_q    [TABLE_ENTRIES];
  logic [63:0]              boot_q  [TABLE_ENTRIES];
  logic [63:0]              epoch_q [TABLE_ENTRIES];
  logic [63:0]              seq_q   [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] match;
  logic [IdxW-1:0]          hit_idx;
  logic [IdxW-1:0]          free_idx;
  logic [63:0]              hit_epoch;
  logic [63:0]              hit_seq;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = valid_q[i] && (id_q[i] == key_id_i) && (boot_q[i] == key_boot_i);
    end
  end

  // at most one entry matches, so the hit fields are an or of masked entries
  always_comb begin
    hit_idx   = '0;
    hit_epoch = '0;
    hit_seq   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx   = hit_idx | i[IdxW-1:0];
        hit_epoch = hit_epoch | epoch_q[i];
        hit_seq   = hit_seq | seq_q[i];
      end
    end
  end

  // lowest free slot wins
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = i[IdxW-1:0];
      end
    end
  end

  assign lookup_o.hit      = |match;
  assign lookup_o.full     = &valid_q;
  assign lookup_o.epoch    = hit_epoch;
  assign lookup_o.last_seq = hit_seq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.install) begin
      valid_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.install) begin
      id_q[free_idx]    <= key_id_i;
      boot_q[free_idx]  <= key_boot_i;
      epoch_q[free_idx] <= ins_epoch_i;
      seq_q[free_idx]   <= '0;
    end else if (wr_i.update) begin
      seq_q[hit_idx] <= seq_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/ptrc_check.sv */
// ordered install and validate checks giving the verdict and table writes
// depends on ptrc_pkg
`default_nettype none

module ptrc_check (
  input  wire ptrc_pkg::req_t    req_i,
  input  wire ptrc_pkg::lookup_t lookup_i,
  output logic                   accepted_o,
  output ptrc_pkg::reason_e      reason_o,
  output ptrc_pkg::wr_t          wr_o
);

  always_comb begin
    reason_o = ptrc_pkg::RSN_OK;
    unique case (req_i.req_type)
      ptrc_pkg::REQ_INSTALL: begin
        priority if (req_i.claimed_id == '0 || req_i.claimed_boot == '0 ||
                     req_i.epoch == '0) begin
          reason_o = ptrc_pkg::RSN_INVALID;
        end else if (lookup_i.hit) begin
          reason_o = ptrc_pkg::RSN_DUPLICATE;
        end else if (lookup_i.full) begin
          reason_o = ptrc_pkg::RSN_FULL;
        end else begin
          reason_o = ptrc_pkg::RSN_OK;
        end
      end
      ptrc_pkg::REQ_VALIDATE: begin
        // the unused credential code counts as valid
        priority if (req_i.cred_status == ptrc_pkg::CRED_EXPIRED) begin
          reason_o = ptrc_pkg::RSN_EXPIRED;
        end else if (req_i.cred_status == ptrc_pkg::CRED_REVOKED) begin
          reason_o = ptrc_pkg::RSN_REVOKED;
        end else if (req_i.auth_id != req_i.claimed_id ||
                     req_i.auth_boot != req_i.claimed_boot) begin
          reason_o = ptrc_pkg::RSN_SPOOFED;
        end else if (!lookup_i.hit) begin
          reason_o = ptrc_pkg::RSN_UNKNOWN;
        end else if (req_i.epoch < lookup_i.epoch) begin
          reason_o = ptrc_pkg::RSN_OLD_EPOCH;
        end else if (req_i.epoch > lookup_i.epoch) begin
          reason_o = ptrc_pkg::RSN_FUTURE_EPOCH;
        end else if (req_i.sequence_req <= lookup_i.last_seq) begin
          reason_o = ptrc_pkg::RSN_REPLAY;
        end else begin
          reason_o = ptrc_pkg::RSN_OK;
        end
      end
      default: reason_o = ptrc_pkg::RSN_OK;
    endcase
  end

  assign accepted_o = (reason_o == ptrc_pkg::RSN_OK);
  assign wr_o.install = accepted_o && (req_i.req_type == ptrc_pkg::REQ_INSTALL);
  assign wr_o.update  = accepted_o && (req_i.req_type == ptrc_pkg::REQ_VALIDATE);

endmodule

`default_nettype wire

/* hdl/producer_trust_replay_check_top.sv */
// channel   | dir | payload
// req_i     | in  | req_type, claimed/auth id and boot, cred_status, epoch, sequence_req
// rsp_o     | out | accepted, reason
//
// one request a cycle unless the response stalls: input register, one pass through
// the parallel tag match over TABLE_ENTRIES entries and the 64-bit epoch and
// sequence compares, result register. the table is written on the edge the request
// leaves the input register, so the next request sees it.
// reset clears the entry valid bits and both stage flags; no clearing pass.
// a stalled response holds the result register and the input register behind it.
//
// depends on ptrc_pkg, ptrc_if, ptrc_table and ptrc_check
`default_nettype none

module producer_trust_replay_check_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ptrc_req_if.sink    req_i,
  ptrc_rsp_if.source  rsp_o
);

  ptrc_pkg::req_t    req_q;
  logic              req_vld_q;
  logic              rsp_vld_q;
  logic              accepted_q;
  ptrc_pkg::reason_e reason_q;

  ptrc_pkg::lookup_t lookup;
  ptrc_pkg::wr_t     wr_raw;
  ptrc_pkg::wr_t     wr;
  logic              accepted;
  ptrc_pkg::reason_e reason;
  logic              adv;
  logic              req_fire;

  assign adv      = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || adv;
  assign req_fire = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (req_fire) begin
        req_vld_q <= 1'b1;
      end else if (adv) begin
        req_vld_q <= 1'b0;
      end
      if (adv) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q.req_type     <= req_i.req_type;
      req_q.claimed_id   <= req_i.claimed_id;
      req_q.claimed_boot <= req_i.claimed_boot;
      req_q.auth_id      <= req_i.auth_id;
      req_q.auth_boot    <= req_i.auth_boot;
      req_q.cred_status  <= req_i.cred_status;
      req_q.epoch        <= req_i.epoch;
      req_q.sequence_req <= req_i.sequence_req;
    end
    if (adv) begin
      accepted_q <= accepted;
      reason_q   <= reason;
    end
  end

  ptrc_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_id_i    (req_q.claimed_id),
    .key_boot_i  (req_q.claimed_boot),
    .ins_epoch_i (req_q.epoch),
    .seq_i       (req_q.sequence_req),
    .wr_i        (wr),
    .lookup_o    (lookup)
  );

  ptrc_check u_check (
    .req_i      (req_q),
    .lookup_i   (lookup),
    .accepted_o (accepted),
    .reason_o   (reason),
    .wr_o       (wr_raw)
  );

  // table writes only when the request actually moves on
  assign wr.install = wr_raw.install && adv;
  assign wr.update  = wr_raw.update && adv;

  assign rsp_o.valid    = rsp_vld_q;
  assign rsp_o.accepted = accepted_q;
  assign rsp_o.reason   = reason_q;

  a_adv_gives_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> rsp_o.valid)
    else $error("request left the input register without a response");

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> req_vld_q)
    else $error("accepted request not held in the input register");

  a_verdict_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.accepted == (rsp_o.reason == ptrc_pkg::RSN_OK)))
    else $error("accepted flag disagrees with reason");

  a_single_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr.install && wr.update))
    else $error("install and sequence update in one cycle");

endmodule

`default_nettype wire
